// ----- src/trim_pkg.sv -----
package trim_pkg;

  // Map geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = $clog2(MAP_DEPTH);

  // Field widths
  localparam int ID_W   = 8;
  localparam int POS_W  = 8;
  localparam int DIM_W  = 9;
  localparam int REQ_W  = 2;
  localparam int CFG_W  = 9;
  localparam int CIDX_W = 1;

  // Compare width: holds pos + size, and the map limits themselves
  localparam int LIM_W_X = $clog2(MAX_WIDTH + 1);
  localparam int LIM_W_Y = $clog2(MAX_HEIGHT + 1);
  localparam int LIM_W   = (LIM_W_X > LIM_W_Y) ? LIM_W_X : LIM_W_Y;
  localparam int CMP_W   = (LIM_W > DIM_W + 1) ? LIM_W : DIM_W + 1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(256);

  typedef enum logic [REQ_W-1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_LOOKUP     = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
    logic [ID_W-1:0]  widget_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] region_id;
    logic            clipped;
  } rsp_t;

endpackage

// ----- src/trim_ram.sv -----
module trim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/touch_region_id_map.sv -----
// Touch region id map: one widget id per pixel of the area in use.
//
// Input channel (in_valid_i / in_ready_o, payload in_data_i) carries one
// request per transaction: register or unregister a rectangle, look up one
// point, or clear the whole area in use. Output channel (out_valid_o /
// out_ready_i, payload out_data_o) returns exactly one result per request.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) sets the width and height
// in use; write it only while no request is in flight.
//
// Occupancy: a lookup inside the area passes through S_LOOK for the
// synchronous map read. A rectangle or clear walks the cells written inside
// the area; the single write port of the map writes one cell a cycle. Any
// other request is done at its acceptance.
// Result: with the output register free, it is valid in the cycle after
// acceptance when no cell is read or written; a lookup's follows the map read, a fill's its last cell.
// Reset: the map is swept to zero, one cell a cycle, all MAX_WIDTH * MAX_HEIGHT
// cells (65536 as built); no request is taken during the sweep.
// Stall: a finished result waits in the output register while the next request
// is taken; a second result waits in a holding register and stalls the input.
module touch_region_id_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  trim_pkg::req_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output trim_pkg::rsp_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [trim_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [trim_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_LOOK,
    S_DONE
  } state_e;

  state_e                         state_q;
  logic                           sweep_q;      // fill pass is the reset sweep
  logic [trim_pkg::COL_W-1:0]     col_q;
  logic [trim_pkg::ROW_W-1:0]     row_q;
  logic [trim_pkg::COL_W-1:0]     xs_q;         // first column of each row
  logic [trim_pkg::CMP_W-1:0]     xe_q;         // one past last column
  logic [trim_pkg::CMP_W-1:0]     ye_q;         // one past last row
  logic [trim_pkg::ID_W-1:0]      val_q;        // id written by the fill pass
  logic                           clip_q;
  trim_pkg::rsp_t                 res_q;        // result held while output busy
  logic                           out_valid_q;
  trim_pkg::rsp_t                 out_q;
  logic [trim_pkg::CFG_W-1:0]     width_q;
  logic [trim_pkg::CFG_W-1:0]     height_q;

  logic [trim_pkg::CMP_W-1:0]     eff_w, eff_h;
  logic [trim_pkg::CMP_W-1:0]     x_ext, y_ext, xe_full, ye_full;
  logic [trim_pkg::CMP_W-1:0]     xs_n, ys_n, xe_n, ye_n;
  logic                           clip_n, empty_n, in_area;
  logic [trim_pkg::ID_W-1:0]      val_n;
  logic                           accept;
  logic                           line_end, last_cell;
  logic [trim_pkg::CMP_W-1:0]     col_inc, row_inc;
  logic                           res_v;
  trim_pkg::rsp_t                 res_d;
  logic                           slot_free;

  logic                           ram_we, ram_re;
  logic [trim_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [trim_pkg::ID_W-1:0]      ram_rdata;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Request decode: clip the addressed rectangle against the area in use, or take the whole area for a clear.
  always_comb begin
    eff_w = (trim_pkg::CMP_W'(width_q) > trim_pkg::CMP_W'(trim_pkg::MAX_WIDTH))
          ? trim_pkg::CMP_W'(trim_pkg::MAX_WIDTH) : trim_pkg::CMP_W'(width_q);
    eff_h = (trim_pkg::CMP_W'(height_q) > trim_pkg::CMP_W'(trim_pkg::MAX_HEIGHT))
          ? trim_pkg::CMP_W'(trim_pkg::MAX_HEIGHT) : trim_pkg::CMP_W'(height_q);
    x_ext   = trim_pkg::CMP_W'(in_data_i.pos_x);
    y_ext   = trim_pkg::CMP_W'(in_data_i.pos_y);
    xe_full = x_ext + trim_pkg::CMP_W'(in_data_i.rect_width);
    ye_full = y_ext + trim_pkg::CMP_W'(in_data_i.rect_height);
    in_area = (x_ext < eff_w) && (y_ext < eff_h);

    if (in_data_i.req_type == trim_pkg::REQ_CLEAR) begin
      xs_n   = '0;
      ys_n   = '0;
      xe_n   = eff_w;
      ye_n   = eff_h;
      clip_n = 1'b0;
      val_n  = '0;
    end else begin
      xs_n   = x_ext;
      ys_n   = y_ext;
      xe_n   = (xe_full > eff_w) ? eff_w : xe_full;
      ye_n   = (ye_full > eff_h) ? eff_h : ye_full;
      clip_n = (in_data_i.rect_width != '0) && (in_data_i.rect_height != '0) &&
               ((xe_full > eff_w) || (ye_full > eff_h));
      val_n  = (in_data_i.req_type == trim_pkg::REQ_REGISTER) ? in_data_i.widget_id : '0;
    end
    empty_n = (xs_n >= xe_n) || (ys_n >= ye_n);
    if (in_data_i.req_type != trim_pkg::REQ_CLEAR) begin
      empty_n = empty_n || (in_data_i.rect_width == '0) || (in_data_i.rect_height == '0);
    end
  end

  // Fill walker: advance the column, wrap to the next row at the line end.
  assign col_inc   = trim_pkg::CMP_W'(col_q) + trim_pkg::CMP_W'(1);
  assign row_inc   = trim_pkg::CMP_W'(row_q) + trim_pkg::CMP_W'(1);
  assign line_end  = (col_inc == xe_q);
  assign last_cell = line_end && (row_inc == ye_q);

  // Result produced this cycle, if any.
  always_comb begin
    res_v = 1'b0;
    res_d = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.req_type == trim_pkg::REQ_LOOKUP) begin
            res_v         = !in_area;
            res_d.clipped = 1'b1;
          end else begin
            res_v         = empty_n;
            res_d.clipped = clip_n;
          end
        end
      end
      S_FILL: begin
        res_v         = last_cell && !sweep_q;
        res_d.clipped = clip_q;
      end
      S_LOOK: begin
        res_v           = 1'b1;
        res_d.region_id = ram_rdata;
      end
      S_DONE: begin
        res_v = 1'b1;
        res_d = res_q;
      end
      default: begin
        res_v = 1'b0;
      end
    endcase
  end

  // Map ports: the fill pass writes, a lookup reads at its acceptance.
  assign ram_we    = (state_q == S_FILL);
  assign ram_waddr = trim_pkg::ADDR_W'(row_q) * trim_pkg::ADDR_W'(trim_pkg::MAX_WIDTH)
                   + trim_pkg::ADDR_W'(col_q);
  assign ram_re    = accept && (in_data_i.req_type == trim_pkg::REQ_LOOKUP) && in_area;
  assign ram_raddr = trim_pkg::ADDR_W'(in_data_i.pos_y)
                   * trim_pkg::ADDR_W'(trim_pkg::MAX_WIDTH)
                   + trim_pkg::ADDR_W'(in_data_i.pos_x);

  trim_ram #(
    .WIDTH (trim_pkg::ID_W),
    .DEPTH (trim_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= trim_pkg::WIDTH_RST;
      height_q <= trim_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        trim_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        trim_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  // Sequencer: state, fill walker and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Start with a sweep of the whole map to zero.
      state_q     <= S_FILL;
      sweep_q     <= 1'b1;
      col_q       <= '0;
      row_q       <= '0;
      xs_q        <= '0;
      xe_q        <= trim_pkg::CMP_W'(trim_pkg::MAX_WIDTH);
      ye_q        <= trim_pkg::CMP_W'(trim_pkg::MAX_HEIGHT);
      val_q       <= '0;
      clip_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the output once taken.
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.req_type == trim_pkg::REQ_LOOKUP) begin
              if (in_area) begin
                state_q <= S_LOOK;
              end
            end else if (!empty_n) begin
              state_q <= S_FILL;
              col_q   <= trim_pkg::COL_W'(xs_n);
              row_q   <= trim_pkg::ROW_W'(ys_n);
              xs_q    <= trim_pkg::COL_W'(xs_n);
              xe_q    <= xe_n;
              ye_q    <= ye_n;
              val_q   <= val_n;
              clip_q  <= clip_n;
            end
          end
        end
        S_FILL: begin
          if (last_cell) begin
            state_q <= S_IDLE;
            sweep_q <= 1'b0;
          end else if (line_end) begin
            col_q <= xs_q;
            row_q <= trim_pkg::ROW_W'(row_inc);
          end else begin
            col_q <= trim_pkg::COL_W'(col_inc);
          end
        end
        S_LOOK: begin
          state_q <= S_IDLE;
        end
        S_DONE: begin
          state_q <= S_DONE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Hand the result to the output register, or hold it until free.
      if (res_v) begin
        if (slot_free) begin
          out_valid_q <= 1'b1;
          out_q       <= res_d;
          state_q     <= S_IDLE;
        end else begin
          res_q   <= res_d;
          state_q <= S_DONE;
        end
      end
    end
  end

endmodule
